[sv/mpq_pkg.sv]
`default_nettype none

package mpq_pkg;

  localparam int DEF_CAPACITY      = 1024;
  localparam int DEF_KEY_WIDTH     = 32;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  localparam int ACTION_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2
  } action_t;

endpackage

`default_nettype wire

[sv/mpq_ram.sv]
`default_nettype none

module mpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/min_priority_queue.sv]
// Bounded min-priority queue of (signed key, payload) entries held as a binary
// min-heap in one single-port-read, single-port-write RAM.
// Input channel: in_valid / in_stall carry one beat per request. in_action
// selects insert, pop of the smallest entry, or peek at it. Output channel:
// out_valid / out_stall return exactly one beat per request with found, the
// entry's key and payload (zero when nothing is returned), the entry count
// after the request, and an error flag.
// The block works on one request at a time; in_stall is high from the beat
// after acceptance until the result has been loaded into the output register.
// Each request walks at most one root-to-leaf path through the RAM, whose
// read port is registered. Insert starts the new entry at the end of the heap
// and moves it up while its parent's key is larger, shifting each such parent
// down; peek reads the root; pop reads the root, then the last entry, and
// sinks that entry while its smaller child (the left one on a tie) has a
// smaller key, shifting each such child up; a pop that empties the queue only
// reads the root. A refused request (insert when full, pop or peek when empty,
// unused action) changes nothing.
// Synchronous reset empties the queue at once; the RAM is not cleared.
// When the receiver stalls, the result holds in the output register and the
// next request is still taken; its result waits until the register frees.

`default_nettype none

module min_priority_queue
  import mpq_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ACTION_W-1:0]               in_action,
  input  wire logic signed [KEY_WIDTH-1:0]       in_key_in,
  input  wire logic [PAYLOAD_WIDTH-1:0]          in_payload_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_found,
  output logic signed [KEY_WIDTH-1:0]            out_key_out,
  output logic [PAYLOAD_WIDTH-1:0]               out_payload_out,
  output logic [$clog2(CAPACITY+1)-1:0]          out_count,
  output logic                                   out_error
);

  localparam int AW      = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int EW      = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int IW      = AW + 2;
  localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UP    = 9'b000000010,
    S_UPCMP = 9'b000000100,
    S_ROOT  = 9'b000001000,
    S_LAST  = 9'b000010000,
    S_DN    = 9'b000100000,
    S_DNL   = 9'b001000000,
    S_DNR   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  function automatic logic key_lt(input logic [EW-1:0] a, input logic [EW-1:0] b);
    return $signed(a[EW-1 -: KEY_WIDTH]) < $signed(b[EW-1 -: KEY_WIDTH]);
  endfunction

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [EW-1:0]        x_r, x_nxt;
  logic [EW-1:0]        best_r, best_nxt;
  logic                 pop_r, pop_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [EW-1:0]        res_entry_r, res_entry_nxt;
  logic                 res_err_r, res_err_nxt;
  logic                 out_found_r;
  logic [EW-1:0]        out_entry_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_error_r;
  logic                 out_load;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rd;

  logic [IW-1:0]        left_w, right_w, count_ext;
  logic [AW-1:0]        parent_w;
  logic                 left_ok, right_ok;
  logic                 r_lt_l;
  logic [EW-1:0]        pick_w;
  logic [AW-1:0]        pick_pos_w;

  assign left_w     = {1'b0, pos_r, 1'b1};
  assign right_w    = left_w + IW'(1);
  assign count_ext  = IW'(count_r);
  assign left_ok    = left_w < count_ext;
  assign right_ok   = right_w < count_ext;
  assign parent_w   = (pos_r - AW'(1)) >> 1;
  assign r_lt_l     = key_lt(ram_rd, best_r);
  assign pick_w     = r_lt_l ? ram_rd : best_r;
  assign pick_pos_w = r_lt_l ? right_w[AW-1:0] : left_w[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    x_nxt         = x_r;
    best_nxt      = best_r;
    pop_nxt       = pop_r;
    res_found_nxt = res_found_r;
    res_entry_nxt = res_entry_r;
    res_err_nxt   = res_err_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = x_r;
    ram_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_found_nxt = 1'b0;
          res_entry_nxt = '0;
          res_err_nxt   = 1'b0;
          pop_nxt       = (in_action == ACT_POP);
          case (in_action)
            ACT_INSERT: begin
              if (count_r < CAP_C) begin
                x_nxt     = {in_key_in, in_payload_in};
                pos_nxt   = count_r[AW-1:0];
                count_nxt = count_r + COUNT_W'(1);
                state_nxt = S_UP;
              end else begin
                res_err_nxt = 1'b1;
                state_nxt   = S_RESP;
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (count_r == '0) begin
                res_err_nxt = 1'b1;
                state_nxt   = S_RESP;
              end else begin
                ram_raddr = '0;
                state_nxt = S_ROOT;
                if (in_action == ACT_POP) begin
                  count_nxt = count_r - COUNT_W'(1);
                end
              end
            end
            default: begin
              res_err_nxt = 1'b1;
              state_nxt   = S_RESP;
            end
          endcase
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = parent_w;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        ram_we = 1'b1;
        if (key_lt(x_r, ram_rd)) begin
          ram_wdata = ram_rd;
          pos_nxt   = parent_w;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_ROOT: begin
        res_found_nxt = 1'b1;
        res_entry_nxt = ram_rd;
        if (pop_r && (count_r != '0)) begin
          ram_raddr = count_r[AW-1:0];
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_LAST: begin
        x_nxt     = ram_rd;
        pos_nxt   = '0;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (left_ok) begin
          ram_raddr = left_w[AW-1:0];
          state_nxt = S_DNL;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_DNL: begin
        best_nxt = ram_rd;
        if (right_ok) begin
          ram_raddr = right_w[AW-1:0];
          state_nxt = S_DNR;
        end else begin
          ram_we = 1'b1;
          if (key_lt(ram_rd, x_r)) begin
            ram_wdata = ram_rd;
            pos_nxt   = left_w[AW-1:0];
            state_nxt = S_DN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_DNR: begin
        ram_we = 1'b1;
        if (key_lt(pick_w, x_r)) begin
          ram_wdata = pick_w;
          pos_nxt   = pick_pos_w;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    x_r         <= x_nxt;
    best_r      <= best_nxt;
    pop_r       <= pop_nxt;
    res_found_r <= res_found_nxt;
    res_entry_r <= res_entry_nxt;
    res_err_r   <= res_err_nxt;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_entry_r <= res_entry_r;
      out_count_r <= count_r;
      out_error_r <= res_err_r;
    end
  end

  mpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_key_out     = out_entry_r[EW-1 -: KEY_WIDTH];
  assign out_payload_out = out_entry_r[PAYLOAD_WIDTH-1:0];
  assign out_count       = out_count_r;
  assign out_error       = out_error_r;

endmodule

`default_nettype wire

[sv/mpq_chk.sv]
`default_nettype none

module mpq_chk
  import mpq_pkg::*;
#(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_found,
  input wire logic signed [KEY_WIDTH-1:0]       out_key_out,
  input wire logic [PAYLOAD_WIDTH-1:0]          out_payload_out,
  input wire logic [$clog2(CAPACITY+1)-1:0]     out_count,
  input wire logic                              out_error
);

  localparam int COUNT_W = $clog2(CAPACITY + 1);

  // A returned entry and a refusal never share one beat.
  a_found_excl_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_error))
    else $error("result beat has both found and error set");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= COUNT_W'(CAPACITY)))
    else $error("reported count exceeds capacity");

  // Every accepted request raises in_stall, so back-to-back beats are never taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_key_out)
                                  && $stable(out_payload_out)
                                  && $stable(out_count)))
    else $error("stalled result beat changed");

endmodule

bind min_priority_queue mpq_chk #(
  .CAPACITY      (CAPACITY),
  .KEY_WIDTH     (KEY_WIDTH),
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_mpq_chk (.*);

`default_nettype wire
